// ===== rtl/sd_card_spi_mode_target_top_macros.svh =====
// assertion macros for the sd card spi target checker
// no dependencies
`ifndef SD_CARD_SPI_MODE_TARGET_TOP_MACROS_SVH
`define SD_CARD_SPI_MODE_TARGET_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define SDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdc check failed");
// next-cycle implication checked outside reset
`define SDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdc check failed");
`endif

// ===== rtl/sdc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and functions for the sd card spi target
// no dependencies
package sdc_pkg;
  localparam int NUM_BLOCKS = 64;
  localparam int BLOCK_BYTES = 512;
  localparam int MEM_DEPTH = NUM_BLOCKS * BLOCK_BYTES;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int PADDR_W = 4;

  localparam logic [PADDR_W-1:0] REG_PRESENT = 4'h0;
  localparam logic [PADDR_W-1:0] REG_BLOCKS  = 4'h4;
  localparam logic [PADDR_W-1:0] REG_CAP     = 4'h8;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD, PH_RESP, PH_RD_TOKEN, PH_RD, PH_RD_CRC,
    PH_WR_TOKEN, PH_WR, PH_WR_CRC
  } phase_t;

  typedef enum logic [1:0] {CL_IDLE, CL_READ, CL_CLEAR} ctl_t;

  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] crc7_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ 8'h12) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] csd_raw(input logic [3:0] idx, input logic [15:0] cap);
    logic [7:0] r;
    case (idx)
      4'd0: r = 8'h40;
      4'd1: r = 8'h0E;
      4'd3: r = 8'h32;
      4'd4: r = 8'h5B;
      4'd5: r = 8'h59;
      4'd8: r = cap[15:8];
      4'd9: r = cap[7:0];
      4'd10: r = 8'h7F;
      4'd11: r = 8'h80;
      4'd12: r = 8'h0A;
      4'd13: r = 8'h40;
      4'd14: r = 8'h40;
      default: r = 8'h00;
    endcase
    return r;
  endfunction
endpackage

// ===== rtl/sdc_stream_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel carrying spi items or miso bytes
// depends on nothing
interface sdc_in_if;
  logic valid;
  logic ready;
  logic command;
  logic [7:0] data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface sdc_out_if;
  logic valid;
  logic ready;
  logic [7:0] miso_byte;
  modport source (output valid, miso_byte, input ready);
  modport sink (input valid, miso_byte, output ready);
endinterface

// ===== rtl/sd_card_spi_mode_target_top.sv =====
`timescale 1ns / 1ps
// sd card spi-mode target: item input channel, miso output channel, apb config
// Usage:
//   in_ch carries one item per transfer: command=0 is an spi byte exchange
//   (data_byte is mosi), command=1 is a chip-select change (data_byte[0] = nss).
//   out_ch gives one miso_byte for each spi byte exchange, none for select changes.
//   each result is held in the output register; a byte from the card ram also
//   passes the registered read of the single ram port and the read state.
//   throughput: one item every cycle unless out_ch stalls or a ram read is pending.
//   an output register parts the channels; a new item is taken no earlier than
//   the cycle in which the previous result is transferred, so a stalled
//   receiver holds the input.
//   reset: synchronous clear of control state, then a clearing pass writes zero
//   to all 32768 ram bytes, one per cycle; no item is taken during it, apb
//   writes are taken at any time.
//   config: image_mounted at 0x0, block_count at 0x4, capacity_field at 0x8.
// depends on sdc_pkg, sdc_stream_if, sdc_regs, sdc_core
module sd_card_spi_mode_target_top import sdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  sdc_in_if.sink in_ch,
  sdc_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic image_mounted;
  logic [6:0] block_count;
  logic [15:0] capacity_field;

  sdc_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .image_mounted(image_mounted), .block_count(block_count),
    .capacity_field(capacity_field)
  );

  sdc_core u_core (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .image_mounted(image_mounted), .block_count(block_count),
    .capacity_field(capacity_field)
  );
endmodule

// ===== rtl/sdc_ram.sv =====
`timescale 1ns / 1ps
// generic single port ram with registered read
// no dependencies
module sdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/sdc_regs.sv =====
`timescale 1ns / 1ps
// apb configuration registers
// depends on sdc_pkg
module sdc_regs import sdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output logic image_mounted,
  output logic [6:0] block_count,
  output logic [15:0] capacity_field
);
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_mounted <= 1'b0;
      block_count <= '0;
      capacity_field <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_PRESENT: image_mounted <= pwdata[0];
        REG_BLOCKS: block_count <= pwdata[6:0];
        REG_CAP: capacity_field <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      REG_PRESENT: prdata = {31'd0, image_mounted};
      REG_BLOCKS: prdata = {25'd0, block_count};
      REG_CAP: prdata = {16'd0, capacity_field};
      default: prdata = '0;
    endcase
  end
endmodule

// ===== rtl/sdc_core.sv =====
`timescale 1ns / 1ps
// protocol engine: command frames, responses, data streaming around the card ram
// depends on sdc_pkg, sdc_ram, sdc_stream_if
module sdc_core import sdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  sdc_in_if.sink in_ch,
  sdc_out_if.source out_ch,
  input  logic image_mounted,
  input  logic [6:0] block_count,
  input  logic [15:0] capacity_field
);
  phase_t phase;
  ctl_t ctl;
  logic [9:0] cnt;
  logic [47:0] frame;
  logic [7:0] rbuf [5];
  logic [2:0] rlen;
  logic csd_mode;
  logic [BLK_W-1:0] blk;
  logic [15:0] crc;
  logic [7:0] crc7;
  logic [ADDR_W:0] clr_addr;
  logic ov;
  logic [7:0] obyte;
  logic [ADDR_W-1:0] ram_addr;
  logic ram_we;
  logic [7:0] ram_wdata, ram_rdata;

  logic acc;
  // a new item may enter in the cycle the held result is transferred
  assign in_ch.ready = (ctl == CL_IDLE) && (!ov || out_ch.ready);
  assign acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov;
  assign out_ch.miso_byte = obyte;

  logic [5:0] cmd_idx;
  logic [31:0] arg;
  logic [6:0] usable;
  assign cmd_idx = frame[45:40];
  assign arg = frame[39:8];
  assign usable = !image_mounted ? 7'd0 :
                  (block_count < 7'(NUM_BLOCKS) ? block_count : 7'(NUM_BLOCKS));
  logic [ADDR_W-1:0] mem_addr;
  assign mem_addr = {blk, cnt[8:0]};

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = in_ch.data_byte;
    ram_addr = mem_addr;
    if (ctl == CL_CLEAR) begin
      ram_we = 1'b1;
      ram_wdata = 8'h00;
      ram_addr = clr_addr[ADDR_W-1:0];
    end else if (acc && !in_ch.command && phase == PH_WR) begin
      ram_we = 1'b1;
    end
  end

  sdc_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [7:0] csd_b;
  assign csd_b = (cnt[3:0] == 4'd15) ? (crc7 | 8'h01) : csd_raw(cnt[3:0], capacity_field);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      ctl <= CL_CLEAR;
      clr_addr <= '0;
      cnt <= '0;
      ov <= 1'b0;
      frame <= '0;
      rlen <= '0;
      csd_mode <= 1'b0;
      blk <= '0;
      crc <= '0;
      crc7 <= '0;
      for (int i = 0; i < 5; i++) rbuf[i] <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) ov <= 1'b0;
      case (ctl)
        CL_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (ADDR_W+1)'(MEM_DEPTH - 1)) ctl <= CL_IDLE;
        end
        CL_READ: begin
          // memory byte arrives in the cycle after the read
          obyte <= ram_rdata;
          ov <= 1'b1;
          crc <= crc16_add(crc, ram_rdata);
          if (cnt == 10'(BLOCK_BYTES - 1)) begin
            phase <= PH_RD_CRC;
            cnt <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
          ctl <= CL_IDLE;
        end
        default: begin
          if (acc && in_ch.command) begin
            if (in_ch.data_byte[0]) phase <= PH_IDLE;
          end else if (acc) begin
            obyte <= 8'hFF;
            ov <= 1'b1;
            case (phase)
              PH_RESP: begin
                logic [2:0] len;
                phase_t nxt;
                len = rlen;
                nxt = PH_IDLE;
                if (cnt == 0) begin
                  len = 3'd1;
                  case (cmd_idx)
                    6'd0: begin
                      rbuf[0] <= image_mounted ? 8'h01 : 8'h7F;
                      obyte <= image_mounted ? 8'h01 : 8'h7F;
                    end
                    6'd8: begin
                      rbuf[0] <= 8'h01; rbuf[1] <= 8'h00; rbuf[2] <= 8'h00;
                      rbuf[3] <= 8'h01; rbuf[4] <= frame[15:8];
                      obyte <= 8'h01; len = 3'd5;
                    end
                    6'd9: begin
                      obyte <= 8'h00; csd_mode <= 1'b1; nxt = PH_RD_TOKEN;
                    end
                    6'd12: begin
                      rbuf[1] <= 8'h00; obyte <= 8'h01; len = 3'd2;
                    end
                    6'd13: begin
                      rbuf[1] <= 8'h00; obyte <= 8'h00; len = 3'd2;
                    end
                    6'd17, 6'd24: begin
                      if (arg >= {25'd0, usable}) begin
                        obyte <= 8'h40;
                      end else begin
                        obyte <= 8'h00;
                        blk <= arg[BLK_W-1:0];
                        csd_mode <= 1'b0;
                        nxt = (cmd_idx == 6'd17) ? PH_RD_TOKEN : PH_WR_TOKEN;
                      end
                    end
                    6'd16, 6'd41, 6'd55: obyte <= 8'h00;
                    6'd58: begin
                      rbuf[1] <= 8'hC0; rbuf[2] <= 8'h00; rbuf[3] <= 8'h00;
                      rbuf[4] <= 8'h00; obyte <= 8'h00; len = 3'd5;
                    end
                    default: obyte <= 8'h04;
                  endcase
                  rlen <= len;
                end else if (cnt < {7'd0, rlen} && cnt < 10'd5) begin
                  obyte <= rbuf[cnt[2:0]];
                end
                cnt <= cnt + 1'b1;
                if (cnt + 1'b1 >= {7'd0, len}) phase <= (cnt == 0) ? nxt : PH_IDLE;
              end
              PH_RD_TOKEN: begin
                obyte <= 8'hFE;
                phase <= PH_RD;
                crc <= '0;
                crc7 <= '0;
                cnt <= '0;
              end
              PH_RD: begin
                if (csd_mode) begin
                  obyte <= csd_b;
                  crc <= crc16_add(crc, csd_b);
                  crc7 <= crc7_step(crc7, csd_b);
                  if (cnt == 10'd15) begin
                    phase <= PH_RD_CRC;
                    cnt <= '0;
                  end else begin
                    cnt <= cnt + 1'b1;
                  end
                end else begin
                  ov <= 1'b0;
                  ctl <= CL_READ;
                end
              end
              PH_RD_CRC: begin
                if (cnt == 0) begin
                  obyte <= crc[15:8];
                  cnt <= 10'd1;
                end else begin
                  obyte <= crc[7:0];
                  phase <= PH_IDLE;
                  cnt <= '0;
                end
              end
              PH_WR_TOKEN: begin
                if (in_ch.data_byte == 8'hFE) begin
                  phase <= PH_WR;
                  cnt <= '0;
                end
              end
              PH_WR: begin
                if (cnt == 10'(BLOCK_BYTES - 1)) begin
                  phase <= PH_WR_CRC;
                  cnt <= '0;
                end else begin
                  cnt <= cnt + 1'b1;
                end
              end
              PH_WR_CRC: begin
                obyte <= 8'h05;
                if (cnt >= 10'd1) begin
                  phase <= PH_IDLE;
                  cnt <= '0;
                end else begin
                  cnt <= cnt + 1'b1;
                end
              end
              PH_CMD, PH_IDLE: begin
                if (phase == PH_IDLE && in_ch.data_byte == 8'hFF) begin
                  obyte <= 8'hFF;
                end else begin
                  logic [9:0] c;
                  c = (phase == PH_IDLE) ? 10'd1 : cnt + 1'b1;
                  frame <= {frame[39:0], in_ch.data_byte};
                  obyte <= 8'h00;
                  if (c > 10'd5) begin
                    phase <= PH_RESP;
                    cnt <= '0;
                  end else begin
                    phase <= PH_CMD;
                    cnt <= c;
                  end
                end
              end
              default: phase <= PH_IDLE;
            endcase
          end
        end
      endcase
    end
  end
endmodule

// ===== rtl/sdc_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the sd card spi target, bound to the top level
// depends on sd_card_spi_mode_target_top_macros.svh
`include "sd_card_spi_mode_target_top_macros.svh"
module sdc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_command,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_byte,
  input logic pready
);
  `SDC_ASSERT_IMP(a_no_take_while_full, out_valid && !out_ready, !in_ready)
  `SDC_ASSERT_NEXT(a_select_no_result, in_valid && in_ready && in_command && !out_valid,
    !out_valid)
  `SDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))
  `SDC_ASSERT_IMP(a_pready, 1'b1, pready)
endmodule

bind sd_card_spi_mode_target_top sdc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_command(in_ch.command), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_byte(out_ch.miso_byte), .pready(pready)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the sd card spi-mode target: directed commands, then random
// frames, data blocks and noise across several register settings
// depends on sdc_pkg, sdc_stream_if and sd_card_spi_mode_target_top
module tb;
  import sdc_pkg::*;

  class sd_card_scoreboard;
    bit image_mounted;
    bit [6:0] block_count;
    bit [15:0] capacity_field;
    phase_t ph;
    int unsigned cnt;
    bit [47:0] frame;
    bit [7:0] resp_buf [5];
    int unsigned resp_len;
    bit csd_sel;
    int unsigned blk;
    bit [15:0] crc;
    bit [7:0] mem [MEM_DEPTH];
    bit [7:0] miso_q [$];
    int errors;

    function new();
      ph = PH_IDLE;
    endfunction

    function bit [15:0] crc16_next(bit [15:0] c, bit [7:0] b);
      c = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
    endfunction

    function bit [7:0] csd_at(bit [3:0] idx);
      bit [7:0] r [16];
      bit [7:0] c;
      r = '{8'h40, 8'h0E, 8'h00, 8'h32, 8'h5B, 8'h59, 8'h00, 8'h00,
            capacity_field[15:8], capacity_field[7:0], 8'h7F, 8'h80,
            8'h0A, 8'h40, 8'h40, 8'h00};
      c = 0;
      // crc7 kept left-aligned in a byte, low bit forced to one
      for (int i = 0; i < 15; i++) begin
        c = c ^ r[i];
        for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ 8'h12) : (c << 1);
      end
      r[15] = c | 8'h01;
      return r[idx];
    endfunction

    function void set_r1(bit [7:0] s);
      resp_buf[0] = s & 8'h7F;
      resp_len = 1;
    endfunction

    function phase_t decode_frame();
      bit [5:0] idx;
      bit [31:0] addr;
      int unsigned usable;
      idx = frame[45:40];
      addr = frame[39:8];
      usable = !image_mounted ? 0 : (block_count < NUM_BLOCKS ? block_count : NUM_BLOCKS);
      case (idx)
        0: set_r1(image_mounted ? 8'h01 : 8'hFF);
        8: begin
          resp_buf = '{8'h01, 8'h00, 8'h00, 8'h01, frame[15:8]};
          resp_len = 5;
        end
        9: begin
          set_r1(8'h00);
          csd_sel = 1;
          return PH_RD_TOKEN;
        end
        12: begin
          resp_buf[0] = 8'h01; resp_buf[1] = 8'h00; resp_len = 2;
        end
        13: begin
          resp_buf[0] = 8'h00; resp_buf[1] = 8'h00; resp_len = 2;
        end
        17, 24: begin
          if (addr >= usable) begin
            set_r1(8'h40);
            return PH_IDLE;
          end
          set_r1(8'h00);
          blk = addr;
          csd_sel = 0;
          return (idx == 17) ? PH_RD_TOKEN : PH_WR_TOKEN;
        end
        16, 41, 55: set_r1(8'h00);
        58: begin
          resp_buf = '{8'h00, 8'hC0, 8'h00, 8'h00, 8'h00};
          resp_len = 5;
        end
        default: set_r1(8'h04);
      endcase
      return PH_IDLE;
    endfunction

    // advance the card model by one accepted transfer
    function void note_item(bit cs_item, bit [7:0] v);
      bit [7:0] reply;
      phase_t nxt;
      if (cs_item) begin
        if (v[0]) ph = PH_IDLE;
        return;
      end
      reply = 8'hFF;
      case (ph)
        PH_IDLE, PH_CMD: begin
          if (!(ph == PH_IDLE && v == 8'hFF)) begin
            if (ph == PH_IDLE) begin
              ph = PH_CMD;
              cnt = 0;
            end
            frame = {frame[39:0], v};
            cnt++;
            if (cnt > 5) begin
              ph = PH_RESP;
              cnt = 0;
            end
            reply = 8'h00;
          end
        end
        PH_RESP: begin
          nxt = PH_IDLE;
          if (cnt == 0) nxt = decode_frame();
          if (cnt < resp_len && cnt < 5) reply = resp_buf[cnt];
          cnt++;
          if (cnt >= resp_len) ph = nxt;
        end
        PH_RD_TOKEN: begin
          reply = 8'hFE;
          ph = PH_RD;
          crc = 0;
          cnt = 0;
        end
        PH_RD: begin
          reply = csd_sel ? csd_at(cnt[3:0]) : mem[blk * BLOCK_BYTES + cnt[8:0]];
          crc = crc16_next(crc, reply);
          cnt++;
          if (cnt >= (csd_sel ? 16 : BLOCK_BYTES)) begin
            ph = PH_RD_CRC;
            cnt = 0;
          end
        end
        PH_RD_CRC: begin
          if (cnt == 0) begin
            reply = crc[15:8];
            cnt = 1;
          end else begin
            reply = crc[7:0];
            ph = PH_IDLE;
            cnt = 0;
          end
        end
        PH_WR_TOKEN: begin
          if (v == 8'hFE) begin
            ph = PH_WR;
            cnt = 0;
          end
        end
        PH_WR: begin
          mem[blk * BLOCK_BYTES + cnt[8:0]] = v;
          cnt++;
          if (cnt >= BLOCK_BYTES) begin
            ph = PH_WR_CRC;
            cnt = 0;
          end
        end
        PH_WR_CRC: begin
          reply = 8'h05;
          cnt++;
          if (cnt >= 2) begin
            ph = PH_IDLE;
            cnt = 0;
          end
        end
        default: ph = PH_IDLE;
      endcase
      miso_q.push_back(reply);
    endfunction

    function void check_miso(bit [7:0] got);
      bit [7:0] want;
      if (miso_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected miso transfer 0x%02h", got);
        return;
      end
      want = miso_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("miso mismatch: expected 0x%02h, got 0x%02h", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  sdc_in_if in_ch();
  sdc_out_if out_ch();
  sd_card_spi_mode_target_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sd_card_scoreboard sb = new;
  bit no_gaps;
  int item_total;

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.command = 0;
    in_ch.data_byte = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_item(in_ch.command, in_ch.data_byte);
    if (!rst && out_ch.valid && out_ch.ready) sb.check_miso(out_ch.miso_byte);
  end

  // receiver: random stall before each miso transfer
  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_ch.ready <= 0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  task automatic send(bit cs_item, bit [7:0] v);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 5);
    if (n > 0) begin
      in_ch.valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.command <= cs_item;
    in_ch.data_byte <= v;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    item_total++;
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] a, logic [31:0] d);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (a)
      REG_PRESENT: sb.image_mounted = d[0];
      REG_BLOCKS: sb.block_count = d[6:0];
      default: sb.capacity_field = d[15:0];
    endcase
  endtask

  // registers change only with the card quiet and every miso byte collected
  task automatic set_config(bit present, bit [6:0] blocks, bit [15:0] cap);
    in_ch.valid <= 0;
    while (sb.miso_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    reg_write(REG_PRESENT, {31'h0, present});
    reg_write(REG_BLOCKS, {25'h0, blocks});
    reg_write(REG_CAP, {16'h0, cap});
  endtask

  // one command frame, then clock out the response and any data phase
  task automatic card_command(bit [5:0] idx, bit [31:0] arg, bit [1:0] top,
                              bit [7:0] tail, bit [7:0] fill);
    send(0, {top, idx});
    for (int i = 3; i >= 0; i--) send(0, arg[8*i +: 8]);
    send(0, tail);
    do send(0, 8'hFF); while (sb.ph == PH_RESP);
    while (sb.ph == PH_RD_TOKEN || sb.ph == PH_RD || sb.ph == PH_RD_CRC)
      send(0, 8'($urandom_range(0, 255)));
    if (sb.ph == PH_WR_TOKEN) begin
      repeat ($urandom_range(0, 2)) send(0, 8'($urandom_range(0, 253)));
      send(0, 8'hFE);
      for (int i = 0; i < BLOCK_BYTES; i++)
        send(0, (fill == 0) ? 8'($urandom_range(0, 255)) : 8'(fill ^ i));
      send(0, 8'($urandom_range(0, 255)));
      send(0, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(int stop_at);
    int sel;
    bit [5:0] idx;
    bit [31:0] arg;
    int unsigned nblk;
    nblk = sb.block_count > NUM_BLOCKS ? NUM_BLOCKS : sb.block_count;
    while (item_total < stop_at) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 19);
      if (sel < 2) begin
        send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (sel == 2) begin
        send(1, {7'($urandom_range(0, 127)), 1'b1});
        send(1, {7'($urandom_range(0, 127)), 1'b0});
      end else begin
        case ($urandom_range(0, 13))
          0: idx = 0;  1: idx = 8;  2: idx = 9;  3: idx = 12;
          4: idx = 13; 5: idx = 16; 6: idx = 41; 7: idx = 55;
          8: idx = 58; 9: idx = 17; 10: idx = 24;
          default: idx = 6'($urandom_range(0, 62));
        endcase
        arg = $urandom;
        if ((idx == 17 || idx == 24) && $urandom_range(0, 2) != 0)
          arg = $urandom_range(0, nblk + 1);
        if (idx == 24 && $urandom_range(0, 1) == 0) arg = 32'hFFFF_FFFF;
        card_command(idx, arg, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 0);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: every command, register extremes, range limits, deselect
    set_config(1, 7'd64, 16'hFFFF);
    send(1, 8'h00);
    send(0, 8'hFF);
    card_command(0, 0, 2'b01, 8'h95, 0);
    card_command(8, 32'h0000_01AA, 2'b01, 8'h87, 0);
    card_command(9, 0, 2'b01, 8'hFF, 0);
    card_command(58, 0, 2'b11, 8'h00, 0);
    card_command(55, 0, 2'b01, 8'h01, 0);
    card_command(41, 32'h4000_0000, 2'b01, 8'h01, 0);
    card_command(16, 32'h0000_0200, 2'b01, 8'h01, 0);
    card_command(16, 32'h0000_0064, 2'b01, 8'h01, 0);
    card_command(13, 0, 2'b01, 8'h01, 0);
    card_command(12, 0, 2'b01, 8'h01, 0);
    card_command(5, 0, 2'b01, 8'h01, 0);
    card_command(24, 63, 2'b01, 8'h01, 8'hA5);
    card_command(17, 63, 2'b01, 8'h01, 0);
    card_command(17, 64, 2'b01, 8'h01, 0);
    card_command(24, 32'hFFFF_FFFF, 2'b01, 8'h01, 0);
    send(0, 8'h51);
    send(0, 8'h00);
    send(1, 8'hFF);
    send(0, 8'hFF);
    card_command(9, 0, 2'b01, 8'h01, 0);

    set_config(0, 7'd0, 16'h0000);
    card_command(0, 0, 2'b01, 8'h95, 0);
    card_command(17, 0, 2'b01, 8'h01, 0);
    card_command(9, 0, 2'b01, 8'h01, 0);
    random_phase(item_total + 150);

    set_config(1, 7'd1, 16'($urandom_range(0, 65535)));
    random_phase(item_total + 170);

    set_config(1, 7'($urandom_range(2, 64)), 16'($urandom_range(0, 65535)));
    random_phase(item_total + 170);

    set_config(1, 7'd64, 16'($urandom_range(0, 65535)));
    random_phase(item_total + 170);

    in_ch.valid <= 0;
    while (sb.miso_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.miso_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
